// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked out of reset.
`define RME_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define RME_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/rme_pkg.sv
// Types, widths and constants of the rotation-matrix-to-Euler pipeline.
package rme_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int ANGLE_WIDTH   = 16;
  localparam int THR_WIDTH     = 15;
  localparam int OP_WIDTH      = ELEMENT_WIDTH + 1;
  localparam int SUM_WIDTH     = 2 * ELEMENT_WIDTH;
  localparam int RES_WIDTH     = SUM_WIDTH + 1;
  localparam int CORDIC_WIDTH  = 60;
  localparam int Z_WIDTH       = 34;
  localparam int CORDIC_STEPS  = 31;
  localparam int CORDIC_STAGES = CORDIC_STEPS + 3;
  localparam int NORM_BIT      = 55;
  localparam int SHIFT_WIDTH   = $clog2(NORM_BIT + 1);
  localparam int ANG_FRAC      = 30;
  localparam int ROUND_SHIFT   = ANG_FRAC - (ANGLE_WIDTH - 3);
  localparam int ANGLE_LIMIT   = 25736;

  localparam logic signed [Z_WIDTH-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_WIDTH-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic signed [ANGLE_WIDTH-1:0]   angle_t;

  typedef struct packed {
    elem_t r00;
    elem_t r10;
    elem_t r11;
    elem_t r12;
    elem_t r20;
    elem_t r21;
    elem_t r22;
  } in_t;

  typedef struct packed {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
    logic   singular;
  } out_t;

  function automatic logic signed [Z_WIDTH-1:0] atan_q30(input int unsigned i);
    logic signed [Z_WIDTH-1:0] a;
    unique case (i)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      default: a = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/rotation_matrix_to_euler.sv
// Top level: rotation matrix to XYZ Euler angles, fully pipelined.
//
// Input beats carry seven matrix entries (Q2.14) on in_valid/in_ready; output
// beats carry roll, pitch, yaw (Q3.13 radians) and a gimbal-lock flag on
// out_valid/out_ready. cfg_wen/cfg_wdata write the singular threshold.
// One beat enters per cycle while in_ready is high. The depth is set mainly
// by the 16 root stages and the 34-stage CORDIC (normalise, fold, 31 steps,
// round) that roll, pitch and yaw each own.
// Every stage holds a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up and in_ready stays high while
// empty stages remain, even with a result waiting at the output.
// When the receiver stalls the pipeline fills and then in_ready drops; no
// beat is lost or repeated.
// Reset clears the valid bits and sets the threshold to one.
`include "assert_macros.svh"

module rotation_matrix_to_euler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [rme_pkg::THR_WIDTH-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rme_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rme_pkg::out_t                     out_data
);

  localparam int EW = rme_pkg::ELEMENT_WIDTH;
  localparam int OW = rme_pkg::OP_WIDTH;
  localparam int SW = rme_pkg::SUM_WIDTH;
  localparam int RW = rme_pkg::RES_WIDTH;
  localparam int CS = rme_pkg::CORDIC_STAGES;
  localparam int QI = 3 + EW;
  localparam int N  = QI + 1 + CS;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [RW-1:0] res;
    rme_pkg::in_t  mat;
  } sq_t;

  logic [rme_pkg::THR_WIDTH-1:0] thr;
  logic [N-1:0]                  v, en;

  rme_pkg::in_t   mat0, mat1;
  logic [EW-1:0]  a00, a10;
  logic [SW-1:0]  p00, p10;
  sq_t            sq [EW+1];

  logic [EW-1:0]        rnd;
  logic                 sing_now;
  logic signed [OW-1:0] px, py, rx, ry, wx, wy;
  logic                 sing_q;
  logic                 sing_p [CS];

  rme_pkg::angle_t roll_a, pitch_a, yaw_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rme_pkg::THR_WIDTH'(1);
    end else if (cfg_wen) begin
      thr <= cfg_wdata;
    end
  end

  assign en[N-1] = ~v[N-1] | out_ready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[N-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mat0 <= in_data;
    end
  end

  assign a00 = mat0.r00[EW-1] ? EW'(-mat0.r00) : EW'(mat0.r00);
  assign a10 = mat0.r10[EW-1] ? EW'(-mat0.r10) : EW'(mat0.r10);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p00  <= SW'(a00) * SW'(a00);
      p10  <= SW'(a10) * SW'(a10);
      mat1 <= mat0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sq[0].rem <= p00 + p10;
      sq[0].res <= '0;
      sq[0].mat <= mat1;
    end
  end

  for (genvar k = 0; k < EW; k++) begin : g_root
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (EW - 1 - k));
    logic [RW-1:0] t;
    logic          ge;
    assign t  = sq[k].res + BIT;
    assign ge = {1'b0, sq[k].rem} >= t;
    always_ff @(posedge clk) begin
      if (en[3+k]) begin
        sq[k+1].mat <= sq[k].mat;
        if (ge) begin
          sq[k+1].rem <= sq[k].rem - t[SW-1:0];
          sq[k+1].res <= (sq[k].res >> 1) + BIT;
        end else begin
          sq[k+1].rem <= sq[k].rem;
          sq[k+1].res <= sq[k].res >> 1;
        end
      end
    end
  end

  assign rnd      = sq[EW].res[EW-1:0] + EW'({1'b0, sq[EW].rem} > sq[EW].res);
  assign sing_now = rnd < EW'(thr);

  always_ff @(posedge clk) begin
    if (en[QI]) begin
      sing_q <= sing_now;
      px     <= signed'({1'b0, rnd});
      py     <= -OW'(sq[EW].mat.r20);
      wx     <= OW'(sq[EW].mat.r00);
      wy     <= OW'(sq[EW].mat.r10);
      if (sing_now) begin
        rx <= OW'(sq[EW].mat.r11);
        ry <= -OW'(sq[EW].mat.r12);
      end else begin
        rx <= OW'(sq[EW].mat.r22);
        ry <= OW'(sq[EW].mat.r21);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[QI+1]) begin
      sing_p[0] <= sing_q;
    end
    for (int c = 1; c < CS; c++) begin
      if (en[QI+1+c]) begin
        sing_p[c] <= sing_p[c-1];
      end
    end
  end

  rme_cordic u_roll (
    .clk   (clk),
    .en    (en[QI+1 +: CS]),
    .x_in  (rx),
    .y_in  (ry),
    .angle (roll_a)
  );

  rme_cordic u_pitch (
    .clk   (clk),
    .en    (en[QI+1 +: CS]),
    .x_in  (px),
    .y_in  (py),
    .angle (pitch_a)
  );

  rme_cordic u_yaw (
    .clk   (clk),
    .en    (en[QI+1 +: CS]),
    .x_in  (wx),
    .y_in  (wy),
    .angle (yaw_a)
  );

  always_comb begin
    out_data.roll     = roll_a;
    out_data.pitch    = pitch_a;
    out_data.yaw      = sing_p[CS-1] ? '0 : yaw_a;
    out_data.singular = sing_p[CS-1];
  end

  `RME_ASSERT_IMP(a_sing_yaw, out_valid && out_data.singular, out_data.yaw == '0, "yaw not dropped")
  `RME_ASSERT_IMP(a_range, out_valid, (out_data.roll <= rme_pkg::ANGLE_LIMIT) && (out_data.roll >= -rme_pkg::ANGLE_LIMIT) && (out_data.pitch <= rme_pkg::ANGLE_LIMIT) && (out_data.pitch >= -rme_pkg::ANGLE_LIMIT), "angle out of range")
  `RME_ASSERT_NXT(a_take, in_valid && in_ready, v[0], "accepted beat not held")

endmodule

// File: rtl/rme_cordic.sv
// Pipelined CORDIC atan2: normalise, quadrant fold, 31 vectoring steps, round.
module rme_cordic (
  input  logic                                     clk,
  input  logic [rme_pkg::CORDIC_STAGES-1:0]        en,
  input  logic signed [rme_pkg::OP_WIDTH-1:0]      x_in,
  input  logic signed [rme_pkg::OP_WIDTH-1:0]      y_in,
  output logic signed [rme_pkg::ANGLE_WIDTH-1:0]   angle
);

  localparam int OW = rme_pkg::OP_WIDTH;
  localparam int CW = rme_pkg::CORDIC_WIDTH;
  localparam int ZW = rme_pkg::Z_WIDTH;
  localparam int NS = rme_pkg::CORDIC_STEPS;
  localparam int SW = rme_pkg::SHIFT_WIDTH;
  localparam int RS = rme_pkg::ROUND_SHIFT;

  logic [OW-1:0]          ax, ay, am;
  logic [SW-1:0]          msb;
  logic signed [OW-1:0]   x0, y0;
  logic [SW-1:0]          sh0;
  logic                   zero0;

  logic signed [CW-1:0]   xn, yn;
  logic signed [CW-1:0]   xs [NS+1];
  logic signed [CW-1:0]   ys [NS+1];
  logic signed [ZW-1:0]   zs [NS+1];
  logic                   zp [NS+1];

  logic signed [ZW-1:0]   zsat, zrnd;

  always_comb begin
    ax = x_in[OW-1] ? OW'(-x_in) : OW'(x_in);
    ay = y_in[OW-1] ? OW'(-y_in) : OW'(y_in);
    am = (ax > ay) ? ax : ay;
    msb = '0;
    for (int b = 0; b < OW; b++) begin
      if (am[b]) begin
        msb = SW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0    <= x_in;
      y0    <= y_in;
      sh0   <= SW'(rme_pkg::NORM_BIT) - msb;
      zero0 <= (am == '0);
    end
  end

  assign xn = CW'(x0) <<< sh0;
  assign yn = CW'(y0) <<< sh0;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      zp[0] <= zero0;
      if (xn < 0) begin
        if (yn >= 0) begin
          xs[0] <= yn;
          ys[0] <= -xn;
          zs[0] <= rme_pkg::HALF_PI_Q30;
        end else begin
          xs[0] <= -yn;
          ys[0] <= xn;
          zs[0] <= -rme_pkg::HALF_PI_Q30;
        end
      end else begin
        xs[0] <= xn;
        ys[0] <= yn;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = rme_pkg::atan_q30(i);
    always_ff @(posedge clk) begin
      if (en[2+i]) begin
        zp[i+1] <= zp[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN;
        end
      end
    end
  end

  always_comb begin
    if (zs[NS] > rme_pkg::PI_Q30) begin
      zsat = rme_pkg::PI_Q30;
    end else if (zs[NS] < -rme_pkg::PI_Q30) begin
      zsat = -rme_pkg::PI_Q30;
    end else begin
      zsat = zs[NS];
    end
    zrnd = (zsat + (ZW'(1) <<< (RS - 1))) >>> RS;
  end

  always_ff @(posedge clk) begin
    if (en[NS+2]) begin
      angle <= zp[NS] ? '0 : zrnd[rme_pkg::ANGLE_WIDTH-1:0];
    end
  end

endmodule
